// ===== rtl/core/zrsc_pkg.sv =====
// Shared constants, codes and types of the zero-run stream classifier.
`default_nettype none

package zrsc_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int RATE_W      = 19;
   localparam int MIN_RUN_W   = 12;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 19;
   localparam int SCALE_W     = 17;

   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_RATE = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_RUN     = 8'd1;

   localparam logic [RATE_W-1:0]    RATE_RESET    = 19'd48000;
   localparam logic [MIN_RUN_W-1:0] MIN_RUN_RESET = 12'd240;

   localparam logic [SAMPLE_W-1:0] SAMPLE_ZERO     = 16'h0000;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MOST_NEG = 16'h8000;

   // mean bound: 100000 * sum <= 99479 * samples
   localparam logic [SCALE_W-1:0] MEAN_SCALE = 17'd100000;
   localparam logic [SCALE_W-1:0] MEAN_LIMIT = 17'd99479;

   typedef enum logic [1:0] {
      VERDICT_NONE  = 2'd0,
      VERDICT_FULL  = 2'd1,
      VERDICT_HALF  = 2'd2,
      VERDICT_SHORT = 2'd3
   } verdict_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_SHORT,
      BK_CLASS,
      BK_BLOCKS,
      BK_MEAN_LO,
      BK_MEAN_HI,
      BK_NQ,
      BK_SS,
      BK_LHS,
      BK_RHS,
      BK_DONE
   } back_state_type;

endpackage

`default_nettype wire

// ===== rtl/core/zrsc_if.sv =====
// Channel interfaces: sample input, verdict output and register write port.
`default_nettype none

interface zrsc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [zrsc_pkg::SAMPLE_W-1:0] sample;
   logic                                 last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

interface zrsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] verdict;

   modport source (output valid, output verdict, input ready);
   modport sink   (input valid, input verdict, output ready);
endinterface

interface zrsc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [zrsc_pkg::CSR_INDEX_W-1:0] index;
   logic [zrsc_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/zero_run_stream_classifier_top.sv =====
// Top level of the zero-run stream classifier: registers, front, queue, back and multiplier.
//
//   port     dir   beat                      payload
//   req_ch   in    one audio sample          sample (s16), last
//   rsp_ch   out   one verdict per stream    verdict (2 bits)
//   csr_ch   in    one register write        index (0 sample_rate, 1 min_run), data
//
// Samples are taken one per cycle; the front updates its counters in that cycle.
// A last sample pushes a snapshot into a two-entry queue; the back spends up to
// 14 shift-add multiplies on it. The front stalls only while two snapshots wait.
// Synchronous reset clears counters, queue, back state and restores register defaults.
`default_nettype none

module zero_run_stream_classifier_top #(
   parameter int COUNT_BITS = 24
) (
   input  logic       clock,
   input  logic       reset,
   zrsc_req_if.sink   req_ch,
   zrsc_rsp_if.source rsp_ch,
   zrsc_csr_if.sink   csr_ch
);

   localparam int SNAP_W = 9*COUNT_BITS;
   localparam int MUL_AW = 3*COUNT_BITS;
   localparam int MUL_BW = (COUNT_BITS > zrsc_pkg::RATE_W) ? COUNT_BITS : zrsc_pkg::RATE_W;

   logic [zrsc_pkg::RATE_W-1:0]    rate_ff, rate_in;
   logic [zrsc_pkg::MIN_RUN_W-1:0] min_run_ff, min_run_in;

   logic                     q_push;
   logic                     q_pop;
   logic                     q_full;
   logic                     q_empty;
   logic [SNAP_W-1:0]        q_push_data;
   logic [SNAP_W-1:0]        q_head;

   logic                     mul_start;
   logic                     mul_busy;
   logic                     mul_done;
   logic [MUL_AW-1:0]        mul_a;
   logic [MUL_BW-1:0]        mul_b;
   logic [MUL_AW+MUL_BW-1:0] mul_product;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      rate_in    = rate_ff;
      min_run_in = min_run_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            zrsc_pkg::CSR_SAMPLE_RATE: rate_in    = csr_ch.data[zrsc_pkg::RATE_W-1:0];
            zrsc_pkg::CSR_MIN_RUN:     min_run_in = csr_ch.data[zrsc_pkg::MIN_RUN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff    <= zrsc_pkg::RATE_RESET;
         min_run_ff <= zrsc_pkg::MIN_RUN_RESET;
      end else begin
         rate_ff    <= rate_in;
         min_run_ff <= min_run_in;
      end
   end

   zrsc_front #(
      .CB (COUNT_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .min_run (min_run_ff),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_data  (q_push_data)
   );

   zrsc_queue #(
      .W (SNAP_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   zrsc_mul #(
      .AW (MUL_AW),
      .BW (MUL_BW)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .busy    (mul_busy),
      .done    (mul_done),
      .product (mul_product)
   );

   zrsc_back #(
      .CB     (COUNT_BITS),
      .MUL_AW (MUL_AW),
      .MUL_BW (MUL_BW)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .rate        (rate_ff),
      .q_empty     (q_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .mul_start   (mul_start),
      .mul_a       (mul_a),
      .mul_b       (mul_b),
      .mul_done    (mul_done),
      .mul_product (mul_product),
      .rsp         (rsp_ch)
   );

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("snapshot popped from an empty queue");

   a_mul_not_busy: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_busy)
      else $error("multiply started while one is running");

   a_pop_gives_result: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_ch.valid)
      else $error("snapshot retired without a verdict beat");

   a_result_from_pop: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(q_pop))
      else $error("verdict beat without a retired snapshot");

endmodule

`default_nettype wire

// ===== rtl/core/zrsc_front.sv =====
// Front end: takes samples, tracks open runs and per-class statistics, queues a snapshot on last.
`default_nettype none

module zrsc_front #(
   parameter int CB = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   zrsc_req_if.sink                          req,
   input  logic [zrsc_pkg::MIN_RUN_W-1:0]    min_run,
   input  logic                              q_full,
   output logic                              q_push,
   output logic [9*CB-1:0]                   q_data
);

   localparam int SQ_W  = 2*CB;
   localparam int CLS_W = 4*CB;

   logic [CB-1:0]   count_ff, count_in;
   logic [CB-1:0]   run_ff [2];
   logic [CB-1:0]   run_in [2];
   logic [SQ_W-1:0] run_sq_ff [2];
   logic [SQ_W-1:0] run_sq_in [2];
   logic [CB-1:0]   blk_ff [2];
   logic [CB-1:0]   blk_in [2];
   logic [CB-1:0]   sum_ff [2];
   logic [CB-1:0]   sum_in [2];
   logic [SQ_W-1:0] sq_sum_ff [2];
   logic [SQ_W-1:0] sq_sum_in [2];

   logic            accept;
   logic            is_class [2];
   logic            is_other;
   logic [CB:0]     sum_wide [2];
   logic [SQ_W:0]   sq_wide [2];

   function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] x);
      sat_inc = (&x) ? x : x + CB'(1);
   endfunction

   assign req.ready = !q_full;

   always_comb begin
      accept      = req.valid && !q_full;
      is_class[0] = $unsigned(req.sample) == zrsc_pkg::SAMPLE_ZERO;
      is_class[1] = $unsigned(req.sample) == zrsc_pkg::SAMPLE_MOST_NEG;
      is_other    = !is_class[0] && !is_class[1];

      count_in = count_ff;
      for (int c = 0; c < 2; c++) begin
         run_in[c]    = run_ff[c];
         run_sq_in[c] = run_sq_ff[c];
         blk_in[c]    = blk_ff[c];
         sum_in[c]    = sum_ff[c];
         sq_sum_in[c] = sq_sum_ff[c];
         sum_wide[c]  = {1'b0, sum_ff[c]} + {1'b0, run_ff[c]};
         sq_wide[c]   = {1'b0, sq_sum_ff[c]} + {1'b0, run_sq_ff[c]};
      end

      if (accept) begin
         count_in = sat_inc(count_ff);
         for (int c = 0; c < 2; c++) begin
            if (is_class[c]) begin
               run_in[c] = sat_inc(run_ff[c]);
               // (r+1)^2 = r^2 + 2r + 1, frozen once the run saturates
               if (!(&run_ff[c])) begin
                  run_sq_in[c] = run_sq_ff[c] + SQ_W'({run_ff[c], 1'b1});
               end
            end else if (is_other) begin
               if (run_ff[c] >= CB'(min_run)) begin
                  blk_in[c]    = sat_inc(blk_ff[c]);
                  sum_in[c]    = sum_wide[c][CB] ? '1 : sum_wide[c][CB-1:0];
                  sq_sum_in[c] = sq_wide[c][SQ_W] ? '1 : sq_wide[c][SQ_W-1:0];
               end
               run_in[c]    = '0;
               run_sq_in[c] = '0;
            end
         end
      end

      q_push = accept && req.last;

      q_data = '0;
      q_data[0 +: CB] = count_in;
      for (int c = 0; c < 2; c++) begin
         q_data[CB + c*CLS_W        +: CB]   = blk_in[c];
         q_data[CB + c*CLS_W + CB   +: CB]   = sum_in[c];
         q_data[CB + c*CLS_W + 2*CB +: SQ_W] = sq_sum_in[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || q_push) begin
         count_ff <= '0;
         for (int c = 0; c < 2; c++) begin
            run_ff[c]    <= '0;
            run_sq_ff[c] <= '0;
            blk_ff[c]    <= '0;
            sum_ff[c]    <= '0;
            sq_sum_ff[c] <= '0;
         end
      end else begin
         count_ff <= count_in;
         for (int c = 0; c < 2; c++) begin
            run_ff[c]    <= run_in[c];
            run_sq_ff[c] <= run_sq_in[c];
            blk_ff[c]    <= blk_in[c];
            sum_ff[c]    <= sum_in[c];
            sq_sum_ff[c] <= sq_sum_in[c];
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/zrsc_queue.sv =====
// Two-entry snapshot queue between front and back.
`default_nettype none

module zrsc_queue #(
   parameter int W = 216
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   input  logic         pop,
   output logic         full,
   output logic         empty,
   output logic [W-1:0] head
);

   logic [W-1:0] mem_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   always_comb begin
      full      = count_ff == 2'd2;
      empty     = count_ff == 2'd0;
      head      = mem_ff[rd_ptr_ff];
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/zrsc_mul.sv =====
// Shift-add multiplier, one multiplier bit per cycle, stops early when the rest is zero.
`default_nettype none

module zrsc_mul #(
   parameter int AW = 72,
   parameter int BW = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [AW-1:0]    a,
   input  logic [BW-1:0]    b,
   output logic             busy,
   output logic             done,
   output logic [AW+BW-1:0] product
);

   localparam int PW = AW + BW;

   logic [PW-1:0] a_ff, a_in;
   logic [PW-1:0] acc_ff, acc_in;
   logic [BW-1:0] b_ff, b_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = PW'(a);
         b_in    = b;
         acc_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (b_ff[0]) begin
               acc_in = acc_ff + a_ff;
            end
            a_in = a_ff << 1;
            b_in = b_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign busy    = busy_ff;
   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

// ===== rtl/core/zrsc_back.sv =====
// Back end: works out the verdict for one queued snapshot through the shared multiplier.
`default_nettype none

module zrsc_back #(
   parameter int CB     = 24,
   parameter int MUL_AW = 72,
   parameter int MUL_BW = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [zrsc_pkg::RATE_W-1:0]    rate,
   input  logic                           q_empty,
   input  logic [9*CB-1:0]                q_head,
   output logic                           q_pop,
   output logic                           mul_start,
   output logic [MUL_AW-1:0]              mul_a,
   output logic [MUL_BW-1:0]              mul_b,
   input  logic                           mul_done,
   input  logic [MUL_AW+MUL_BW-1:0]       mul_product,
   zrsc_rsp_if.source                     rsp
);

   localparam int SQ_W  = 2*CB;
   localparam int CLS_W = 4*CB;
   localparam int PW    = MUL_AW + MUL_BW;
   localparam int CW    = CB + 3;

   zrsc_pkg::back_state_type state_ff, state_in;
   zrsc_pkg::verdict_type    result_ff, result_in;
   zrsc_pkg::verdict_type    rsp_verdict_ff, rsp_verdict_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     cls_ff, cls_in;
   logic                     pend_ff, pend_in;
   logic [PW-1:0]            t_ff, t_in;
   logic [SQ_W-1:0]          ss_ff, ss_in;

   logic [CB-1:0]   n_all;
   logic [CB-1:0]   blk_n;
   logic [CB-1:0]   sum_s;
   logic [SQ_W-1:0] sq_q;
   logic [CW-1:0]   five_n;
   logic            too_short;
   logic            want_mul;
   logic            fail;
   logic            pass;

   always_comb begin
      n_all  = q_head[0 +: CB];
      blk_n  = cls_ff ? q_head[CB + CLS_W +: CB]          : q_head[CB +: CB];
      sum_s  = cls_ff ? q_head[CB + CLS_W + CB +: CB]     : q_head[2*CB +: CB];
      sq_q   = cls_ff ? q_head[CB + CLS_W + 2*CB +: SQ_W] : q_head[3*CB +: SQ_W];
      five_n = (CW'(n_all) << 2) + CW'(n_all);
      too_short = (rate == '0) || (five_n < CW'(rate));

      state_in       = state_ff;
      result_in      = result_ff;
      cls_in         = cls_ff;
      pend_in        = pend_ff;
      t_in           = t_ff;
      ss_in          = ss_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_verdict_in = rsp_verdict_ff;
      q_pop          = 1'b0;
      want_mul       = 1'b0;
      fail           = 1'b0;
      pass           = 1'b0;
      mul_a          = '0;
      mul_b          = '0;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         zrsc_pkg::BK_IDLE: begin
            if (!q_empty) begin
               state_in = zrsc_pkg::BK_SHORT;
            end
         end
         zrsc_pkg::BK_SHORT: begin
            if (too_short) begin
               result_in = zrsc_pkg::VERDICT_SHORT;
               state_in  = zrsc_pkg::BK_DONE;
            end else begin
               cls_in   = 1'b0;
               state_in = zrsc_pkg::BK_CLASS;
            end
         end
         zrsc_pkg::BK_CLASS: begin
            if ({sum_s, 1'b0} >= {1'b0, n_all}) begin
               state_in = zrsc_pkg::BK_BLOCKS;
            end else begin
               fail = 1'b1;
            end
         end
         zrsc_pkg::BK_BLOCKS: begin
            // n >= floor(16N/R)  <=>  (n+1)*R > 16N
            want_mul = 1'b1;
            mul_a    = MUL_AW'(blk_n) + MUL_AW'(1);
            mul_b    = MUL_BW'(rate);
            if (mul_done) begin
               pend_in = 1'b0;
               if (mul_product > (PW'(n_all) << 4)) begin
                  state_in = zrsc_pkg::BK_MEAN_LO;
               end else begin
                  fail = 1'b1;
               end
            end
         end
         zrsc_pkg::BK_MEAN_LO: begin
            want_mul = 1'b1;
            mul_a    = MUL_AW'(sum_s);
            mul_b    = MUL_BW'(zrsc_pkg::MEAN_SCALE);
            if (mul_done) begin
               pend_in  = 1'b0;
               t_in     = mul_product;
               state_in = zrsc_pkg::BK_MEAN_HI;
            end
         end
         zrsc_pkg::BK_MEAN_HI: begin
            want_mul = 1'b1;
            mul_a    = MUL_AW'(n_all);
            mul_b    = MUL_BW'(zrsc_pkg::MEAN_LIMIT);
            if (mul_done) begin
               pend_in = 1'b0;
               if (t_ff <= mul_product) begin
                  state_in = zrsc_pkg::BK_NQ;
               end else begin
                  fail = 1'b1;
               end
            end
         end
         zrsc_pkg::BK_NQ: begin
            want_mul = 1'b1;
            mul_a    = MUL_AW'(sq_q);
            mul_b    = MUL_BW'(blk_n);
            if (mul_done) begin
               pend_in  = 1'b0;
               t_in     = mul_product;
               state_in = zrsc_pkg::BK_SS;
            end
         end
         zrsc_pkg::BK_SS: begin
            want_mul = 1'b1;
            mul_a    = MUL_AW'(sum_s);
            mul_b    = MUL_BW'(sum_s);
            if (mul_done) begin
               pend_in = 1'b0;
               ss_in   = mul_product[SQ_W-1:0];
               // no positive spread left: test passes outright
               if (t_ff <= mul_product) begin
                  pass = 1'b1;
               end else begin
                  state_in = zrsc_pkg::BK_LHS;
               end
            end
         end
         zrsc_pkg::BK_LHS: begin
            want_mul = 1'b1;
            mul_a    = MUL_AW'(t_ff - PW'(ss_ff));
            mul_b    = MUL_BW'(blk_n);
            if (mul_done) begin
               pend_in  = 1'b0;
               t_in     = mul_product;
               state_in = zrsc_pkg::BK_RHS;
            end
         end
         zrsc_pkg::BK_RHS: begin
            want_mul = 1'b1;
            mul_a    = MUL_AW'(ss_ff);
            mul_b    = (blk_n == '0) ? '0 : MUL_BW'(blk_n - CB'(1));
            if (mul_done) begin
               pend_in = 1'b0;
               if ({t_ff, 4'b0000} <= {4'b0000, mul_product}) begin
                  pass = 1'b1;
               end else begin
                  fail = 1'b1;
               end
            end
         end
         zrsc_pkg::BK_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = result_ff;
               q_pop          = 1'b1;
               state_in       = zrsc_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = zrsc_pkg::BK_IDLE;
         end
      endcase

      if (pass) begin
         result_in = cls_ff ? zrsc_pkg::VERDICT_HALF : zrsc_pkg::VERDICT_FULL;
         state_in  = zrsc_pkg::BK_DONE;
      end else if (fail) begin
         if (cls_ff) begin
            result_in = zrsc_pkg::VERDICT_NONE;
            state_in  = zrsc_pkg::BK_DONE;
         end else begin
            cls_in   = 1'b1;
            state_in = zrsc_pkg::BK_CLASS;
         end
      end

      mul_start = want_mul && !pend_ff;
      if (mul_start) begin
         pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= zrsc_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         cls_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         cls_ff       <= cls_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff      <= result_in;
      rsp_verdict_ff <= rsp_verdict_in;
      t_ff           <= t_in;
      ss_ff          <= ss_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.verdict = rsp_verdict_ff;

endmodule

`default_nettype wire
